>>> rtl/mfrs_pkg.sv
// ----------------------------------------------------------------------------
// mfrs_pkg - shared constants and float decode for the reply scanner
// Header bytes, counter widths and the float32 to int16 (x10) conversion.
// ----------------------------------------------------------------------------
package mfrs_pkg;

  localparam int unsigned BUF_SIZE_DEF = 1024;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned MIN_LEN_W    = 11;

  localparam logic [7:0] HDR_ADDR = 8'h01;
  localparam logic [7:0] HDR_FUNC = 8'h03;
  localparam logic [7:0] HDR_LEN  = 8'h04;

  localparam logic [CNT_W-1:0]     COUNT_SAT   = {CNT_W{1'b1}};
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 11'd9;

  localparam logic [15:0] INT16_MAX = 16'h7FFF;
  localparam logic [15:0] INT16_MIN = 16'h8000;

  // Header match progress
  typedef enum logic [1:0] {
    HDR_NONE = 2'd0,
    HDR_GOT1 = 2'd1,
    HDR_GOT2 = 2'd2
  } hdr_stage_t;

  // Single-precision value times ten, single-precision rounding (RNE),
  // truncated toward zero and saturated to int16. NaN gives zero.
  function automatic logic signed [15:0] decode_x10(input logic [31:0] w);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [27:0] prod;
    logic [23:0] keep;
    logic        rbit;
    logic        sticky;
    logic        rnd;
    logic [24:0] sum;
    logic [23:0] mres;
    logic [9:0]  xe;
    logic [9:0]  sh;
    logic [23:0] shifted;
    logic [14:0] mag;
    logic        sat;
    logic [15:0] res;
    sgn  = w[31];
    ex   = w[30:23];
    man  = {1'b1, w[22:0]};
    // man * 10 = man * 8 + man * 2
    prod = {1'b0, man, 3'b000} + {3'b000, man, 1'b0};
    if (prod[27]) begin
      keep   = prod[27:4];
      rbit   = prod[3];
      sticky = |prod[2:0];
      xe     = {2'b00, ex} + 10'd4;
    end else begin
      keep   = prod[26:3];
      rbit   = prod[2];
      sticky = |prod[1:0];
      xe     = {2'b00, ex} + 10'd3;
    end
    rnd = rbit & (sticky | keep[0]);
    sum = {1'b0, keep} + {24'd0, rnd};
    if (sum[24]) begin
      mres = sum[24:1];
      xe   = xe + 10'd1;
    end else begin
      mres = sum[23:0];
    end
    // value = mres * 2^(xe - 150); integer part reaches 2^15 once xe >= 142
    sat = (xe >= 10'd142);
    sh  = 10'd150 - xe;
    if (sat) begin
      mag = '0;
    end else if (sh >= 10'd24) begin
      mag = '0;
    end else begin
      shifted = mres >> sh[4:0];
      mag     = shifted[14:0];
    end
    if (ex == 8'hFF) begin
      // infinity saturates, NaN reads as zero
      if (w[22:0] != 23'd0) res = 16'd0;
      else                  res = sgn ? INT16_MIN : INT16_MAX;
    end else if (ex == 8'h00) begin
      res = 16'd0;
    end else if (sat) begin
      res = sgn ? INT16_MIN : INT16_MAX;
    end else begin
      res = sgn ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    end
    return $signed(res);
  endfunction

endpackage

>>> rtl/modbus_float_reply_scanner_core.sv
// ----------------------------------------------------------------------------
// modbus_float_reply_scanner_core - Modbus read reply float32 scanner
// Scans received byte batches for an 01 03 04 reply header and decodes the
// following big-endian float into a saturated int16 reading times ten.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one received byte per word,
//   with in_batch_end on the last byte of a batch and the batch's channel and
//   quantity. Output channel (out_valid / out_stall) carries one reading word
//   per scanned batch in which a header was found.
//   A batch shorter than the configured minimum is kept and joined to the
//   next one. cfg_wr_en / cfg_wr_data set that minimum (reset value 9).
//   The reading is registered: out_valid rises in the cycle after the batch_end byte is taken.
//   Throughput: one byte per cycle while in_stall is low; the scan state and a
//   single output register are the only stages, the float decode sits ahead
//   of the output register.
//   Reset (rst_n low, synchronous) clears the scan state and the output
//   valid flag and restores the minimum batch length.
//   When the receiver stalls, the waiting reading holds and in_stall rises
//   only while the output register is full and stalled.
// ----------------------------------------------------------------------------
module modbus_float_reply_scanner_core #(
  parameter int unsigned BUF_SIZE = mfrs_pkg::BUF_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  input  logic                                 in_batch_end,
  input  logic [3:0]                           in_channel,
  input  logic                                 in_quantity,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   out_present_value,
  output logic [3:0]                           out_channel,
  output logic                                 out_quantity,
  input  logic                                 cfg_wr_en,
  input  logic [mfrs_pkg::MIN_LEN_W-1:0]       cfg_wr_data
);
  import mfrs_pkg::*;

  localparam logic [CNT_W:0] BufLim = (CNT_W+1)'(BUF_SIZE);

  // Scan state
  hdr_stage_t           hdr_r, hdr_nxt;
  logic [2:0]           dcnt_r, dcnt_nxt;
  logic [31:0]          fword_r, fword_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MIN_LEN_W-1:0] min_len_r;

  // Result register
  logic                 ovalid_r, ovalid_nxt;
  logic signed [15:0]   ovalue_r;
  logic [3:0]           ochan_r;
  logic                 oqty_r;

  logic accept;
  logic emit;
  logic scan_end;
  logic [CNT_W:0] pos_x;

  assign in_stall = ovalid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign pos_x    = {1'b0, cnt_r};

  // Per-byte scan
  always_comb begin
    hdr_nxt   = hdr_r;
    dcnt_nxt  = dcnt_r;
    fword_nxt = fword_r;
    done_nxt  = done_r;
    if (done_r) begin
      if (dcnt_r < 3'd4) begin
        if (pos_x < BufLim) begin
          fword_nxt = fword_r | ({24'd0, in_rx_byte} << {(2'd3 - dcnt_r[1:0]), 3'b000});
        end
        dcnt_nxt = dcnt_r + 3'd1;
      end
    end else if (hdr_r == HDR_GOT2 && in_rx_byte == HDR_LEN) begin
      hdr_nxt = HDR_NONE;
      if (cnt_r >= CNT_W'(2) && (pos_x + (CNT_W+1)'(1)) < BufLim) begin
        done_nxt  = 1'b1;
        fword_nxt = '0;
        dcnt_nxt  = '0;
      end
    end else if (hdr_r == HDR_GOT1 && in_rx_byte == HDR_FUNC) begin
      hdr_nxt = HDR_GOT2;
    end else begin
      hdr_nxt = (in_rx_byte == HDR_ADDR) ? HDR_GOT1 : HDR_NONE;
    end
    cnt_nxt = (cnt_r != COUNT_SAT) ? cnt_r + CNT_W'(1) : cnt_r;

    scan_end = in_batch_end && (cnt_nxt >= {{(CNT_W-MIN_LEN_W){1'b0}}, min_len_r});
    emit     = scan_end & done_nxt;
    if (scan_end) begin
      hdr_nxt   = HDR_NONE;
      dcnt_nxt  = '0;
      done_nxt  = 1'b0;
      cnt_nxt   = '0;
    end
  end

  // Output word hand-off
  always_comb begin
    ovalid_nxt = ovalid_r & out_stall;
    if (accept && emit) ovalid_nxt = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= HDR_NONE;
      dcnt_r    <= '0;
      fword_r   <= '0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
      min_len_r <= MIN_LEN_RST;
      ovalid_r  <= 1'b0;
    end else begin
      if (accept) begin
        hdr_r   <= hdr_nxt;
        dcnt_r  <= dcnt_nxt;
        fword_r <= scan_end ? 32'd0 : fword_nxt;
        done_r  <= done_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_wr_en) min_len_r <= cfg_wr_data;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload, decoded on the way in
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      ovalue_r <= decode_x10(fword_nxt);
      ochan_r  <= in_channel;
      oqty_r   <= in_quantity;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_present_value = ovalue_r;
  assign out_channel       = ochan_r;
  assign out_quantity      = oqty_r;

endmodule

>>> rtl/mfrs_checker.sv
// ----------------------------------------------------------------------------
// mfrs_checker - port-level checks for the reply scanner
// Watches the channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module mfrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_batch_end,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_present_value
);

  // a stalled reading word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_present_value))
    else $error("stalled reading word changed");

  // input is only held off while a reading waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no reading waiting");

  // a new reading follows a taken batch-end byte
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && !in_stall && in_batch_end))
    else $error("reading without batch end");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modbus_float_reply_scanner_core mfrs_checker u_mfrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_batch_end      (in_batch_end),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_present_value (out_present_value)
);
